>>> hw/rtl/online_mlp_sample_predictor_assert.svh
// Assertion macros for the online sample predictor.
// Included by every RTL file that carries concurrent checks; no other dependencies.
`ifndef ONLINE_MLP_SAMPLE_PREDICTOR_ASSERT_SVH
`define ONLINE_MLP_SAMPLE_PREDICTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define OMSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omsp check failed");
`define OMSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omsp check failed");
`else
`define OMSP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OMSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/omsp_pkg.sv
// Shared types, sizes, micro-op codes and helpers of the online sample predictor.
// No dependencies; imported by every module of the block.
package omsp_pkg;

  localparam int WINDOW_LEN   = 8;
  localparam int HIDDEN_UNITS = 3;
  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = 24;
  localparam int NHW          = WINDOW_LEN * HIDDEN_UNITS;

  localparam int K_W    = $clog2(WINDOW_LEN);
  localparam int J_W    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int T_W    = $clog2(HIDDEN_UNITS + 1);
  localparam int HW_AW  = $clog2(NHW);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int WIDX_W = 5;
  localparam int LR_W   = 17;
  localparam int H_W    = FRAC_BITS + 1;
  localparam int OPND_W = DATA_W + 1;
  localparam int PROD_W = 2 * OPND_W;
  localparam int ACC_W  = PROD_W + K_W + 1;
  localparam int SAT_W  = ACC_W + 2;

  localparam logic [H_W-1:0] QONE = H_W'(1) << FRAC_BITS;

  // 2^(-k/16) in Q16, k = 0..16
  localparam logic [H_W-1:0] EXP_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef logic signed [DATA_W-1:0] q_t;

  typedef enum logic [4:0] {
    MOP_NONE,
    MOP_WRITE,
    MOP_FILL,
    MOP_CLR,
    MOP_MAC_HID,
    MOP_SIG_START,
    MOP_SIG_STORE,
    MOP_MAC_OUT,
    MOP_Y,
    MOP_E,
    MOP_MUL_AE,
    MOP_AE,
    MOP_MUL_AEH,
    MOP_UPD_W2,
    MOP_UPD_THO,
    MOP_T_LOAD,
    MOP_MUL_T1H,
    MOP_MUL_TW2,
    MOP_D,
    MOP_MUL_WD,
    MOP_UPD_THH,
    MOP_SHIFT
  } mop_t;

  typedef struct packed {
    mop_t           mop;
    logic           latch;
    logic [J_W-1:0] j;
    logic [K_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic op_w;
    logic win_full;
    logic sig_done;
    logic out_full;
  } stat_t;

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (&v[SAT_W-1:DATA_W-1] || ~|v[SAT_W-1:DATA_W-1]) begin
      r = v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/omsp_sigmoid.sv
// Base-2 sigmoid unit: table lookup with interpolation, then a bit-serial divider.
// Depends on omsp_pkg and the assertion macro header.
`include "online_mlp_sample_predictor_assert.svh"
module omsp_sigmoid import omsp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  q_t             v,
  output logic           done,
  output logic [H_W-1:0] s
);

  localparam int N_W    = DATA_W - FRAC_BITS;
  localparam int P_SH   = 14;
  localparam int BIG_W  = H_W + P_SH;
  localparam int DIV_SH = 30;
  localparam int DEN_W  = DIV_SH + 2;
  localparam int CNT_W  = $clog2(H_W + 1);

  typedef enum logic [2:0] {S_IDLE, S_INTERP, S_DEN, S_DIV, S_FIN} state_t;

  state_t                state;
  logic                  neg;
  logic [DATA_W-1:0]     t;
  logic [H_W-1:0]        p;
  logic [N_W-1:0]        n;
  logic [DEN_W-1:0]      den;
  logic [DEN_W-1:0]      rem;
  logic [H_W-1:0]        nlow;
  logic [H_W-1:0]        q;
  logic [CNT_W-1:0]      cnt;

  logic [3:0]            idx;
  logic [FRAC_BITS-1:0]  frac;
  logic [H_W-1:0]        diff;
  logic [H_W+FRAC_BITS-1:0] dprod;
  logic [H_W-1:0]        p_next;
  logic [BIG_W-1:0]      big;
  logic [DEN_W-1:0]      den_next;
  logic [DEN_W:0]        r2;
  logic                  ge;

  always_comb begin
    idx    = t[FRAC_BITS-1 -: 4];
    frac   = {t[FRAC_BITS-5:0], 4'b0000};
    diff   = EXP_TAB[{1'b0, idx}] - EXP_TAB[{1'b0, idx} + 5'd1];
    dprod  = (H_W+FRAC_BITS)'(diff) * (H_W+FRAC_BITS)'(frac);
    p_next = EXP_TAB[{1'b0, idx}] - dprod[H_W+FRAC_BITS-1:FRAC_BITS];
    big    = (n >= N_W'(40)) ? '0 : ({p, {P_SH{1'b0}}} >> n);
    den_next = (DEN_W'(1) << DIV_SH) + DEN_W'(big);
    r2     = {rem, nlow[H_W-1]};
    ge     = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= v[DATA_W-1];
            t     <= v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          p     <= p_next;
          n     <= t[DATA_W-1:FRAC_BITS];
          state <= S_DEN;
        end
        S_DEN: begin
          // numerator is 2^(F+30) + den/2; its top part is already below den
          den   <= den_next;
          rem   <= (DEN_W'(1) << (FRAC_BITS + DIV_SH - H_W)) + (den_next >> (H_W + 1));
          nlow  <= den_next[H_W:1];
          q     <= '0;
          cnt   <= CNT_W'(H_W);
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= ge ? DEN_W'(r2 - {1'b0, den}) : r2[DEN_W-1:0];
          q     <= {q[H_W-2:0], ge};
          nlow  <= {nlow[H_W-2:0], 1'b0};
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done = (state == S_FIN);
  assign s    = neg ? (QONE - q) : q;

  `OMSP_ASSERT_IMPL(a_start_when_idle, clk, rst, start, state == S_IDLE)

endmodule

>>> hw/rtl/omsp_ctrl.sv
// Sequencer of the predictor: walks the forward pass, the output stage and training.
// Depends on omsp_pkg and the assertion macro header; drives omsp_datapath.
`include "online_mlp_sample_predictor_assert.svh"
module omsp_ctrl import omsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  train_enable,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_HCLR, S_HMAC, S_HDRAIN, S_HSIG, S_HWAIT,
    S_OCLR, S_OMAC, S_ODRAIN, S_Y, S_E,
    S_AE_MUL, S_AE, S_W2_MUL, S_W2_UPD, S_THO,
    S_T1_MUL, S_T1, S_T2_MUL, S_T2, S_D_MUL, S_D, S_HW, S_THH, S_SHIFT
  } state_t;

  localparam logic [J_W-1:0] J_LAST = J_W'(HIDDEN_UNITS - 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(WINDOW_LEN - 1);

  state_t         state, state_next;
  logic [J_W-1:0] j, j_next;
  logic [K_W-1:0] k, k_next;

  always_comb begin
    state_next = state;
    j_next     = j;
    k_next     = k;
    cmd.mop    = MOP_NONE;
    cmd.latch  = 1'b0;
    cmd.j      = j;
    cmd.k      = k;
    unique case (state)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        priority if (stat.op_w) begin
          cmd.mop    = MOP_WRITE;
          state_next = S_IDLE;
        end else if (!stat.win_full) begin
          cmd.mop    = MOP_FILL;
          state_next = S_IDLE;
        end else begin
          j_next     = '0;
          state_next = S_HCLR;
        end
      end
      S_HCLR: begin
        cmd.mop    = MOP_CLR;
        k_next     = '0;
        state_next = S_HMAC;
      end
      S_HMAC: begin
        cmd.mop = MOP_MAC_HID;
        k_next  = k + K_W'(1);
        if (k == K_LAST) state_next = S_HDRAIN;
      end
      S_HDRAIN: state_next = S_HSIG;
      S_HSIG: begin
        cmd.mop    = MOP_SIG_START;
        state_next = S_HWAIT;
      end
      S_HWAIT: begin
        if (stat.sig_done) begin
          cmd.mop = MOP_SIG_STORE;
          if (j == J_LAST) begin
            state_next = S_OCLR;
          end else begin
            j_next     = j + J_W'(1);
            state_next = S_HCLR;
          end
        end
      end
      S_OCLR: begin
        cmd.mop    = MOP_CLR;
        j_next     = '0;
        state_next = S_OMAC;
      end
      S_OMAC: begin
        cmd.mop = MOP_MAC_OUT;
        j_next  = j + J_W'(1);
        if (j == J_LAST) state_next = S_ODRAIN;
      end
      S_ODRAIN: state_next = S_Y;
      S_Y: begin
        cmd.mop    = MOP_Y;
        state_next = S_E;
      end
      S_E: begin
        // hold until the output register is free
        if (!stat.out_full) begin
          cmd.mop    = MOP_E;
          state_next = train_enable ? S_AE_MUL : S_SHIFT;
        end
      end
      S_AE_MUL: begin
        cmd.mop    = MOP_MUL_AE;
        state_next = S_AE;
      end
      S_AE: begin
        cmd.mop    = MOP_AE;
        j_next     = '0;
        state_next = S_W2_MUL;
      end
      S_W2_MUL: begin
        cmd.mop    = MOP_MUL_AEH;
        state_next = S_W2_UPD;
      end
      S_W2_UPD: begin
        cmd.mop = MOP_UPD_W2;
        if (j == J_LAST) begin
          state_next = S_THO;
        end else begin
          j_next     = j + J_W'(1);
          state_next = S_W2_MUL;
        end
      end
      S_THO: begin
        cmd.mop    = MOP_UPD_THO;
        j_next     = '0;
        state_next = S_T1_MUL;
      end
      S_T1_MUL: begin
        cmd.mop    = MOP_MUL_AEH;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.mop    = MOP_T_LOAD;
        state_next = S_T2_MUL;
      end
      S_T2_MUL: begin
        cmd.mop    = MOP_MUL_T1H;
        state_next = S_T2;
      end
      S_T2: begin
        cmd.mop    = MOP_T_LOAD;
        state_next = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.mop    = MOP_MUL_TW2;
        state_next = S_D;
      end
      S_D: begin
        cmd.mop    = MOP_D;
        k_next     = '0;
        state_next = S_HW;
      end
      S_HW: begin
        cmd.mop = MOP_MUL_WD;
        k_next  = k + K_W'(1);
        if (k == K_LAST) state_next = S_THH;
      end
      S_THH: begin
        cmd.mop = MOP_UPD_THH;
        if (j == J_LAST) begin
          state_next = S_SHIFT;
        end else begin
          j_next     = j + J_W'(1);
          state_next = S_T1_MUL;
        end
      end
      S_SHIFT: begin
        cmd.mop    = MOP_SHIFT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  `OMSP_ASSERT_NEXT(a_accept_dispatch, clk, rst, in_valid && !in_stall, state == S_DISP)
  `OMSP_ASSERT_IMPL(a_sig_done_waited, clk, rst, stat.sig_done, state == S_HWAIT)

endmodule

>>> hw/rtl/omsp_datapath.sv
// Datapath: window, weights, shared multiplier, accumulator, sigmoid and output register.
// Depends on omsp_pkg, omsp_sigmoid and the assertion macro header.
`include "online_mlp_sample_predictor_assert.svh"
module omsp_datapath import omsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              op,
  input  q_t                sample,
  input  logic [WIDX_W-1:0] weight_index,
  input  q_t                weight_value,
  input  logic [LR_W-1:0]   learning_rate,
  output logic              out_valid,
  input  logic              out_stall,
  output q_t                prediction,
  output q_t                error
);

  localparam int PQ_W = PROD_W - FRAC_BITS;
  localparam int AQ_W = ACC_W - FRAC_BITS;

  q_t                  win [WINDOW_LEN];
  logic [FILL_W-1:0]   fill;
  q_t                  hw [NHW];
  q_t                  w2 [HIDDEN_UNITS];
  q_t                  thr [HIDDEN_UNITS+1];
  logic [H_W-1:0]      hact [HIDDEN_UNITS];

  logic                op_w;
  q_t                  smp;
  logic [WIDX_W-1:0]   widx;
  q_t                  wval;

  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic                     is_mul;
  logic signed [PROD_W-1:0] prod;
  logic signed [PQ_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [AQ_W-1:0]   acc_q;
  logic                     mac_pend;
  logic signed [OPND_W-1:0] ae, tval;
  q_t                       dval, yval, err_q, e_next, sig_v;
  logic                     out_full;

  logic                hw_pend;
  logic [HW_AW-1:0]    hw_idx, cmd_idx, hw_raddr;
  q_t                  hw_rd;
  logic                sig_done;
  logic [H_W-1:0]      sig_s;

  assign cmd_idx  = HW_AW'(int'(cmd.j) * WINDOW_LEN + int'(cmd.k));
  assign hw_raddr = hw_pend ? hw_idx : cmd_idx;
  assign hw_rd    = hw[hw_raddr];
  assign prod_q   = $signed(prod[PROD_W-1:FRAC_BITS]);
  assign acc_q    = $signed(acc[ACC_W-1:FRAC_BITS]);
  assign sig_v    = sat_q(SAT_W'(acc_q) - SAT_W'(thr[T_W'(cmd.j)]));
  assign e_next   = sat_q(SAT_W'(yval) - SAT_W'(smp));

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    unique case (cmd.mop)
      MOP_MAC_HID: begin
        mul_a = OPND_W'(win[cmd.k]);
        mul_b = OPND_W'(hw_rd);
      end
      MOP_MAC_OUT: begin
        mul_a = $signed({{(OPND_W-H_W){1'b0}}, hact[cmd.j]});
        mul_b = OPND_W'(w2[cmd.j]);
      end
      MOP_MUL_AE: begin
        mul_a = $signed({{(OPND_W-LR_W){1'b0}}, learning_rate});
        mul_b = OPND_W'(err_q);
      end
      MOP_MUL_AEH: begin
        mul_a = ae;
        mul_b = $signed({{(OPND_W-H_W){1'b0}}, hact[cmd.j]});
      end
      MOP_MUL_T1H: begin
        mul_a = tval;
        mul_b = $signed({{(OPND_W-H_W){1'b0}}, QONE - hact[cmd.j]});
      end
      MOP_MUL_TW2: begin
        mul_a = tval;
        mul_b = OPND_W'(w2[cmd.j]);
      end
      MOP_MUL_WD: begin
        mul_a = OPND_W'(win[cmd.k]);
        mul_b = OPND_W'(dval);
      end
      default: is_mul = 1'b0;
    endcase
  end

  omsp_sigmoid u_sigmoid (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mop == MOP_SIG_START),
    .v     (sig_v),
    .done  (sig_done),
    .s     (sig_s)
  );

  // state with a defined reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      mac_pend <= 1'b0;
      hw_pend  <= 1'b0;
      out_full <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) win[i] <= '0;
      for (int i = 0; i < NHW; i++) hw[i] <= '0;
      for (int i = 0; i < HIDDEN_UNITS; i++) w2[i] <= '0;
      for (int i = 0; i < HIDDEN_UNITS + 1; i++) thr[i] <= '0;
    end else begin
      mac_pend <= (cmd.mop == MOP_MAC_HID) || (cmd.mop == MOP_MAC_OUT);
      hw_pend  <= (cmd.mop == MOP_MUL_WD);
      // write back the hidden weight whose product landed last cycle
      if (hw_pend) begin
        hw[hw_idx] <= sat_q(SAT_W'(hw_rd) - SAT_W'(prod_q));
      end
      if (out_full && !out_stall) out_full <= 1'b0;
      unique case (cmd.mop)
        MOP_WRITE: begin
          if (widx < WIDX_W'(NHW)) begin
            hw[widx[HW_AW-1:0]] <= wval;
          end else if (widx < WIDX_W'(NHW + HIDDEN_UNITS)) begin
            w2[J_W'(widx - WIDX_W'(NHW))] <= wval;
          end else if (widx < WIDX_W'(NHW + 2 * HIDDEN_UNITS + 1)) begin
            thr[T_W'(widx - WIDX_W'(NHW + HIDDEN_UNITS))] <= wval;
          end
        end
        MOP_FILL: begin
          win[fill[K_W-1:0]] <= smp;
          fill               <= fill + FILL_W'(1);
        end
        MOP_E:       out_full <= 1'b1;
        MOP_UPD_W2:  w2[cmd.j] <= sat_q(SAT_W'(w2[cmd.j]) - SAT_W'(prod_q));
        MOP_UPD_THO: begin
          thr[T_W'(HIDDEN_UNITS)] <= sat_q(SAT_W'(thr[T_W'(HIDDEN_UNITS)]) + SAT_W'(ae));
        end
        MOP_UPD_THH: begin
          thr[T_W'(cmd.j)] <= sat_q(SAT_W'(thr[T_W'(cmd.j)]) + SAT_W'(dval));
        end
        MOP_SHIFT: begin
          for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
          win[WINDOW_LEN-1] <= smp;
        end
        default: ;
      endcase
    end
  end

  // registers without reset: input payload, product, accumulator and stage results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_w <= op;
      smp  <= sample;
      widx <= weight_index;
      wval <= weight_value;
    end
    if (is_mul) prod <= mul_a * mul_b;
    if (cmd.mop == MOP_CLR) begin
      acc <= '0;
    end else if (mac_pend) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.mop == MOP_SIG_STORE) hact[cmd.j] <= sig_s;
    if (cmd.mop == MOP_Y) yval <= sat_q(SAT_W'(acc_q) - SAT_W'(thr[T_W'(HIDDEN_UNITS)]));
    if (cmd.mop == MOP_E) begin
      err_q      <= e_next;
      prediction <= yval;
      error      <= e_next;
    end
    if (cmd.mop == MOP_AE) ae <= $signed(prod_q[OPND_W-1:0]);
    if (cmd.mop == MOP_T_LOAD) tval <= $signed(prod_q[OPND_W-1:0]);
    if (cmd.mop == MOP_D) dval <= sat_q(SAT_W'(prod_q));
    if (cmd.mop == MOP_MUL_WD) hw_idx <= cmd_idx;
  end

  assign stat.op_w     = op_w;
  assign stat.win_full = (fill == FILL_W'(WINDOW_LEN));
  assign stat.sig_done = sig_done;
  assign stat.out_full = out_full;
  assign out_valid     = out_full;

  `OMSP_ASSERT_IMPL(a_result_into_empty, clk, rst, cmd.mop == MOP_E, !out_full)
  `OMSP_ASSERT_IMPL(a_clear_not_pending, clk, rst, cmd.mop == MOP_CLR, !mac_pend)

endmodule

>>> hw/rtl/online_mlp_sample_predictor.sv
// Top level of the online 8-3-1 perceptron sample predictor.
// Depends on omsp_pkg, omsp_ctrl and omsp_datapath; holds the configuration registers.
//
// Samples (op 0) fill an 8-entry window; once it is full each new sample yields one
// item of prediction and error, followed by a backpropagation step when train_enable
// is set, after which the sample shifts into the window. Weight writes (op 1) and
// samples pushed into a filling window give no result. The shared 25x25 multiplier
// does every product one at a time (24 hidden MACs, 3 output MACs, 37 training
// products), and each of the three sigmoids runs a table stage and a 17-step bit-serial
// divider. The result sits in an output register; the block carries on with training
// and takes the next item while it waits, and its sequencer stalls only when a new
// result is ready before the previous one has been taken.
module online_mlp_sample_predictor import omsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  q_t                sample,
  input  logic [WIDX_W-1:0] weight_index,
  input  q_t                weight_value,
  output logic              out_valid,
  input  logic              out_stall,
  output q_t                prediction,
  output q_t                error,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [LR_W-1:0]   cfg_data
);

  typedef enum logic {CFG_LEARNING_RATE = 1'b0, CFG_TRAIN_ENABLE = 1'b1} cfg_idx_t;

  localparam logic [LR_W-1:0] LR_RESET = LR_W'(26214);

  logic [LR_W-1:0] learning_rate;
  logic            train_enable;
  cmd_t            cmd;
  stat_t           stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      train_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        CFG_TRAIN_ENABLE:  train_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  omsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .train_enable (train_enable),
    .stat         (stat),
    .cmd          (cmd)
  );

  omsp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .sample        (sample),
    .weight_index  (weight_index),
    .weight_value  (weight_value),
    .learning_rate (learning_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .prediction    (prediction),
    .error         (error)
  );

endmodule
